FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the merge cost block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OMC_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OMC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/omc_pkg.sv
// ----------------------------------------------------------------------------
// omc_pkg
// Widths, defaults and helpers shared by the merge cost block.
// ----------------------------------------------------------------------------
package omc_pkg;

  localparam int WEIGHT_W      = 32;
  localparam int SUM_W         = 40;
  localparam int COST_W        = 48;
  localparam int MAX_ITEMS_DEF = 64;

  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

FILE: sv/omc_if.sv
// ----------------------------------------------------------------------------
// omc_if
// Valid/ready channels for weight beats and result beats.
// ----------------------------------------------------------------------------
interface omc_in_if;
  logic                         valid;
  logic                         ready;
  logic [omc_pkg::WEIGHT_W-1:0] weight;
  logic                         last;

  modport source (output valid, output weight, output last, input ready);
  modport sink (input valid, input weight, input last, output ready);
endinterface

interface omc_out_if;
  logic                       valid;
  logic                       ready;
  logic [omc_pkg::COST_W-1:0] total_cost;

  modport source (output valid, output total_cost, input ready);
  modport sink (input valid, input total_cost, output ready);
endinterface

FILE: sv/optimal_adjacent_merge_cost.sv
// ----------------------------------------------------------------------------
// optimal_adjacent_merge_cost
// Minimum total cost of merging a sequence of weights into one.
// ----------------------------------------------------------------------------
// The input channel takes one weight beat per cycle while the sequencer is
// idle; a beat with last set closes the sequence. Beats after the first
// MAX_ITEMS are dropped, though their last flag still closes the sequence.
// After the closing beat, ready stays low while the interval tables fill:
// first the single-item diagonal, then for each interval a bound lookup, a
// read, add and compare step for each candidate split and a write, and
// last a read of the answer. The Knuth-Yao bound keeps the candidate count
// under about 1.5*n*n. The run time is set by the single add and compare
// unit, which sees one split candidate at a time through the two read ports
// of the cost table.
// The result channel carries one beat per sequence from an output register;
// a new sequence may load while it waits. If the receiver stalls, the
// sequencer holds its answer until the output register is free.
// Reset returns to idle with an empty sequence; table contents are not
// cleared since every entry is written before it is read.
// ----------------------------------------------------------------------------
module optimal_adjacent_merge_cost #(
  parameter int MAX_ITEMS = omc_pkg::MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  omc_in_if.sink            in_ch,
  omc_out_if.source         out_ch
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic                        in_accept;
  logic                        start;
  logic [CW-1:0]               seq_len;
  logic [CW-1:0]               ps_lo_addr;
  logic [CW-1:0]               ps_hi_addr;
  logic [omc_pkg::SUM_W-1:0]   ps_lo_data;
  logic [omc_pkg::SUM_W-1:0]   ps_hi_data;
  logic                        dp_idle;
  logic                        dp_done;
  logic [omc_pkg::COST_W-1:0]  dp_result;
  logic                        out_free;
  logic                        out_valid_r;
  logic [omc_pkg::COST_W-1:0]  out_cost_r;

  assign in_ch.ready = dp_idle;
  assign in_accept   = in_ch.valid && dp_idle;
  assign start       = in_accept && in_ch.last;
  assign out_free    = !out_valid_r || out_ch.ready;

  omc_psum #(.MAX_ITEMS(MAX_ITEMS)) u_psum (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_accept),
    .weight     (in_ch.weight),
    .last       (in_ch.last),
    .rd_lo_addr (ps_lo_addr),
    .rd_hi_addr (ps_hi_addr),
    .rd_lo_data (ps_lo_data),
    .rd_hi_data (ps_hi_data),
    .seq_len    (seq_len)
  );

  omc_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .seq_len    (seq_len),
    .ps_lo_addr (ps_lo_addr),
    .ps_hi_addr (ps_hi_addr),
    .ps_lo_data (ps_lo_data),
    .ps_hi_data (ps_hi_data),
    .out_free   (out_free),
    .idle       (dp_idle),
    .done       (dp_done),
    .result     (dp_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_done) begin
      out_cost_r <= dp_result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.total_cost = out_cost_r;

endmodule

FILE: sv/omc_psum.sv
// ----------------------------------------------------------------------------
// omc_psum
// Item counter and prefix sum memory with two registered read ports.
// ----------------------------------------------------------------------------
module omc_psum #(
  parameter int MAX_ITEMS = omc_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [omc_pkg::WEIGHT_W-1:0]       weight,
  input  logic                               last,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]     rd_lo_addr,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]     rd_hi_addr,
  output logic [omc_pkg::SUM_W-1:0]          rd_lo_data,
  output logic [omc_pkg::SUM_W-1:0]          rd_hi_data,
  output logic [$clog2(MAX_ITEMS+1)-1:0]     seq_len
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0]               count_r;
  logic [omc_pkg::SUM_W-1:0]   run_r;
  logic [omc_pkg::SUM_W-1:0]   sum_nxt;
  logic                        room;
  logic [omc_pkg::SUM_W-1:0]   ps_mem [MAX_ITEMS+1];
  logic [omc_pkg::SUM_W-1:0]   rd_lo_r;
  logic [omc_pkg::SUM_W-1:0]   rd_hi_r;
  logic                        lo_zero_r;

  assign room    = count_r < CW'(MAX_ITEMS);
  assign sum_nxt = run_r + omc_pkg::SUM_W'(weight);
  assign seq_len = room ? count_r + CW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      run_r   <= '0;
    end else if (wr_en) begin
      if (last) begin
        count_r <= '0;
        run_r   <= '0;
      end else if (room) begin
        count_r <= count_r + CW'(1);
        run_r   <= sum_nxt;
      end
    end
  end

  // Entry zero is never stored; the low read port returns zero for it.
  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      ps_mem[count_r + CW'(1)] <= sum_nxt;
    end
    rd_lo_r   <= ps_mem[rd_lo_addr];
    rd_hi_r   <= ps_mem[rd_hi_addr];
    lo_zero_r <= (rd_lo_addr == '0);
  end

  assign rd_lo_data = lo_zero_r ? '0 : rd_lo_r;
  assign rd_hi_data = rd_hi_r;

endmodule

FILE: sv/omc_dp.sv
// ----------------------------------------------------------------------------
// omc_dp
// Interval table sequencer with one shared add and compare unit.
// ----------------------------------------------------------------------------
module omc_dp #(
  parameter int MAX_ITEMS = omc_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]     seq_len,
  output logic [$clog2(MAX_ITEMS+1)-1:0]     ps_lo_addr,
  output logic [$clog2(MAX_ITEMS+1)-1:0]     ps_hi_addr,
  input  logic [omc_pkg::SUM_W-1:0]          ps_lo_data,
  input  logic [omc_pkg::SUM_W-1:0]          ps_hi_data,
  input  logic                               out_free,
  output logic                               idle,
  output logic                               done,
  output logic [omc_pkg::COST_W-1:0]         result
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = omc_pkg::idx_width(MAX_ITEMS);
  localparam int TD = 1 << (2 * IW);

  typedef enum logic [3:0] {
    S_IDLE, S_DIAG, S_SPL_RD, S_SPL_WT, S_K_RD, S_K_ADD, S_K_CMP, S_WR, S_FIN_RD, S_FIN_WT
  } state_t;

  state_t                      state_r;
  logic [CW-1:0]               n_r;
  logic [IW-1:0]               i_r;
  logic [IW-1:0]               j_r;
  logic [IW-1:0]               w_r;
  logic [IW-1:0]               k_r;
  logic [IW-1:0]               upper_r;
  logic [omc_pkg::SUM_W-1:0]   seg_r;
  logic [omc_pkg::COST_W-1:0]  sum_r;
  logic [omc_pkg::COST_W-1:0]  best_r;
  logic [IW-1:0]               arg_r;
  logic                        first_r;

  logic [omc_pkg::COST_W-1:0]  cost_mem [TD];
  logic [IW-1:0]               split_mem [TD];
  logic [omc_pkg::COST_W-1:0]  cost_a_r;
  logic [omc_pkg::COST_W-1:0]  cost_b_r;
  logic [IW-1:0]               split_a_r;
  logic [IW-1:0]               split_b_r;

  logic [CW-1:0]               nm1_full;
  logic [IW-1:0]               nm1;
  logic [IW-1:0]               jm1;
  logic [CW-1:0]               j_inc;
  logic [CW-1:0]               w_inc;
  logic                        fin;
  logic                        wr_diag;
  logic                        wr_cell;
  logic [2*IW-1:0]             cost_ra;
  logic [2*IW-1:0]             cost_rb;
  logic [2*IW-1:0]             tab_wa;
  logic [omc_pkg::COST_W-1:0]  cost_wd;
  logic [IW-1:0]               split_wd;

  assign nm1_full = n_r - CW'(1);
  assign nm1      = nm1_full[IW-1:0];
  assign jm1      = j_r - IW'(1);
  assign j_inc    = CW'(j_r) + CW'(1);
  assign w_inc    = CW'(w_r) + CW'(1);
  assign fin      = (state_r == S_FIN_RD) || (state_r == S_FIN_WT);
  assign wr_diag  = (state_r == S_DIAG);
  assign wr_cell  = (state_r == S_WR);

  assign cost_ra  = fin ? {IW'(0), nm1} : {i_r, k_r};
  assign cost_rb  = {k_r + IW'(1), j_r};
  assign tab_wa   = wr_diag ? {i_r, i_r} : {i_r, j_r};
  assign cost_wd  = wr_diag ? '0 : best_r;
  assign split_wd = wr_diag ? i_r : arg_r;

  assign ps_lo_addr = CW'(i_r);
  assign ps_hi_addr = CW'(j_r) + CW'(1);

  always_ff @(posedge clk) begin
    if (wr_diag || wr_cell) begin
      cost_mem[tab_wa]  <= cost_wd;
      split_mem[tab_wa] <= split_wd;
    end
    cost_a_r  <= cost_mem[cost_ra];
    cost_b_r  <= cost_mem[cost_rb];
    split_a_r <= split_mem[{i_r, jm1}];
    split_b_r <= split_mem[{i_r + IW'(1), j_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            n_r     <= seq_len;
            i_r     <= '0;
            state_r <= S_DIAG;
          end
        end
        S_DIAG: begin
          if (CW'(i_r) == nm1_full) begin
            if (n_r == CW'(1)) begin
              state_r <= S_FIN_RD;
            end else begin
              w_r     <= IW'(1);
              i_r     <= '0;
              j_r     <= IW'(1);
              state_r <= S_SPL_RD;
            end
          end else begin
            i_r <= i_r + IW'(1);
          end
        end
        S_SPL_RD: begin
          state_r <= S_SPL_WT;
        end
        S_SPL_WT: begin
          k_r     <= split_a_r;
          upper_r <= (split_b_r < jm1) ? split_b_r : jm1;
          seg_r   <= ps_hi_data - ps_lo_data;
          first_r <= 1'b1;
          state_r <= S_K_RD;
        end
        S_K_RD: begin
          state_r <= S_K_ADD;
        end
        S_K_ADD: begin
          sum_r   <= cost_a_r + cost_b_r + omc_pkg::COST_W'(seg_r);
          state_r <= S_K_CMP;
        end
        S_K_CMP: begin
          if (first_r || (sum_r < best_r)) begin
            best_r <= sum_r;
            arg_r  <= k_r;
          end
          first_r <= 1'b0;
          if (k_r >= upper_r) begin
            state_r <= S_WR;
          end else begin
            k_r     <= k_r + IW'(1);
            state_r <= S_K_RD;
          end
        end
        S_WR: begin
          if (j_inc < n_r) begin
            i_r     <= i_r + IW'(1);
            j_r     <= j_r + IW'(1);
            state_r <= S_SPL_RD;
          end else if (w_inc < n_r) begin
            w_r     <= w_r + IW'(1);
            i_r     <= '0;
            j_r     <= w_r + IW'(1);
            state_r <= S_SPL_RD;
          end else begin
            state_r <= S_FIN_RD;
          end
        end
        S_FIN_RD: begin
          state_r <= S_FIN_WT;
        end
        S_FIN_WT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign idle   = (state_r == S_IDLE);
  assign done   = (state_r == S_FIN_WT) && out_free;
  assign result = cost_a_r;

endmodule

FILE: sv/omc_checker.sv
// ----------------------------------------------------------------------------
// omc_checker
// Port-level checks on the merge cost block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module omc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [omc_pkg::COST_W-1:0] out_total_cost
);

  `OMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `OMC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_total_cost))
  `OMC_ASSERT_NEXT(a_busy_after_last, clk, rst_n, in_valid && in_ready && in_last, !in_ready)
  `OMC_ASSERT_IMPLY(a_result_after_work, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind optimal_adjacent_merge_cost omc_checker u_omc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_last        (in_ch.last),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_total_cost (out_ch.total_cost)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for optimal_adjacent_merge_cost.
// ----------------------------------------------------------------------------
// Weight beats are sent as sequences closed by a last flag. A tracker keeps
// its own prefix sums and recomputes the minimum merge cost of each closed
// sequence with a split-bounded interval table. Every result beat is compared
// with the oldest outstanding cost. The sequences cover the edge weights,
// ties, single items and sequences longer than the block holds. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_ITEMS = omc_pkg::MAX_ITEMS_DEF;
  localparam int TARGET_BEATS = 650;

  class merge_cost_tracker;
    int unsigned seq_len;
    bit [omc_pkg::SUM_W-1:0] running_sum [MAX_ITEMS+1];
    bit [omc_pkg::COST_W-1:0] span_cost [MAX_ITEMS][MAX_ITEMS];
    int unsigned best_split [MAX_ITEMS][MAX_ITEMS];
    bit [omc_pkg::COST_W-1:0] pending_costs [$];
    int unsigned mismatches;

    function new();
      seq_len = 0;
      running_sum[0] = '0;
      mismatches = 0;
    endfunction

    function bit [omc_pkg::COST_W-1:0] min_merge_cost(int unsigned n);
      int unsigned i, w, j, k, lo, hi, arg;
      bit [omc_pkg::SUM_W-1:0] seg;
      bit [omc_pkg::COST_W-1:0] best, trial;
      for (i = 0; i < n; i++) begin
        span_cost[i][i] = '0;
        best_split[i][i] = i;
      end
      for (w = 1; w < n; w++) begin
        for (i = 0; i + w < n; i++) begin
          j = i + w;
          lo = best_split[i][j-1];
          hi = best_split[i+1][j];
          seg = running_sum[j+1] - running_sum[i];
          best = span_cost[i][lo] + span_cost[lo+1][j] + seg;
          arg = lo;
          for (k = lo; k <= hi && k + 1 <= j; k++) begin
            trial = span_cost[i][k] + span_cost[k+1][j] + seg;
            if (trial < best) begin
              best = trial;
              arg = k;
            end
          end
          span_cost[i][j] = best;
          best_split[i][j] = arg;
        end
      end
      return span_cost[0][n-1];
    endfunction

    function void add_weight(bit [omc_pkg::WEIGHT_W-1:0] weight, bit last);
      if (seq_len < MAX_ITEMS) begin
        running_sum[seq_len+1] = running_sum[seq_len] + weight;
        seq_len++;
      end
      if (last) begin
        pending_costs.push_back(min_merge_cost(seq_len));
        seq_len = 0;
      end
    endfunction

    function void check_cost(logic [omc_pkg::COST_W-1:0] actual);
      bit [omc_pkg::COST_W-1:0] expected;
      if (pending_costs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("total_cost %0d arrived with no sequence outstanding", actual);
        return;
      end
      expected = pending_costs.pop_front();
      if (actual !== expected) begin
        mismatches++;
        if (mismatches <= 10)
          $display("total_cost mismatch: expected %0d, actual %0d", expected, actual);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit eager;
  bit hold_output;
  int unsigned beats_sent;
  merge_cost_tracker costs;

  omc_in_if in_ch ();
  omc_out_if out_ch ();

  optimal_adjacent_merge_cost #(
    .MAX_ITEMS(MAX_ITEMS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_beat(bit [omc_pkg::WEIGHT_W-1:0] weight, bit last);
    int unsigned gap;
    gap = eager ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.weight <= weight;
    in_ch.last <= last;
    do @(posedge clk); while (!in_ch.ready);
    costs.add_weight(weight, last);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic bit [omc_pkg::WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return $urandom;
      2: return {omc_pkg::WEIGHT_W{1'b1}} - $urandom_range(0, 3);
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  task automatic send_sequence(int unsigned len, bit all_max);
    int unsigned i;
    for (i = 0; i < len; i++)
      send_beat(all_max ? {omc_pkg::WEIGHT_W{1'b1}} : random_weight(), i == len - 1);
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_output) begin
        stall = 3000;
        hold_output = 1'b0;
      end else begin
        stall = eager ? 0 : $urandom_range(0, 17);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      costs.check_cost(out_ch.total_cost);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned seq_count;
    int unsigned len;
    costs = new();
    beats_sent = 0;
    eager = 1'b0;
    hold_output = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.weight = '0;
    in_ch.last = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat('0, 1'b1);
    send_beat('1, 1'b1);
    send_beat('1, 1'b0);
    send_beat('1, 1'b1);
    repeat (3) send_beat('0, 1'b0);
    send_beat('0, 1'b1);
    repeat (2) send_beat(5, 1'b0);
    send_beat(5, 1'b1);
    send_beat(32'hAAAA_AAAA, 1'b0);
    send_beat(32'h5555_5555, 1'b0);
    send_beat('1, 1'b0);
    send_beat(1, 1'b1);
    send_beat(1, 1'b0);
    send_beat(100, 1'b0);
    send_beat(1, 1'b0);
    send_beat(100, 1'b0);
    send_beat(1, 1'b1);

    send_sequence(MAX_ITEMS, 1'b0);
    send_sequence(MAX_ITEMS + 6, 1'b1);

    eager = 1'b1;
    hold_output = 1'b1;
    repeat (8) send_sequence($urandom_range(1, 4), 1'b0);
    eager = 1'b0;

    seq_count = 0;
    while (beats_sent < TARGET_BEATS) begin
      if (seq_count % 8 == 0)
        eager = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      send_sequence(len, 1'b0);
      seq_count++;
    end
    in_ch.valid <= 1'b0;

    while (costs.pending_costs.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (costs.mismatches == 0 && costs.pending_costs.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: optimal_adjacent_merge_cost.f
+incdir+sv
sv/omc_pkg.sv
sv/omc_if.sv
sv/omc_psum.sv
sv/omc_dp.sv
sv/optimal_adjacent_merge_cost.sv
sv/omc_checker.sv
tb/testbench.sv
